FILE: sv/ctspi_pkg.sv
package ctspi_pkg;

   // sizes
   localparam int PREF_DEPTH   = 128;
   localparam int SYMBOL_COUNT = 94;
   localparam int SYM_IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int SYM_CNT_W    = $clog2(SYMBOL_COUNT + 1);
   localparam int PREF_ADDR_W  = (PREF_DEPTH > 1) ? $clog2(PREF_DEPTH) : 1;
   localparam int PREF_CNT_W   = $clog2(PREF_DEPTH + 1);
   localparam int SYM_W        = 7;
   localparam int COLOR_W      = 24;

   // symbol codes
   localparam logic [7:0]       SYM_FIRST    = 8'd33;
   localparam logic [7:0]       SYM_LAST     = 8'(33 + SYMBOL_COUNT - 1);
   localparam logic [SYM_W-1:0] SYM_FALLBACK = 7'd63;
   localparam logic [SYM_W-1:0] SYM_NEWLINE  = 7'd10;

   // request codes
   localparam logic [1:0] REQ_CLEAR    = 2'd0;
   localparam logic [1:0] REQ_APPEND   = 2'd1;
   localparam logic [1:0] REQ_CLASSIFY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PREF,
      ST_SCAN,
      ST_STORE,
      ST_OUT_CELL,
      ST_OUT_NL
   } state_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] pref_symbol;
      logic       row_end_not_last;
   } req_item_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             new_color;
      logic             last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic       clear;
      logic       push;
      logic       pop;
      logic [7:0] push_symbol;
   } pref_ctrl_type;

   typedef struct packed {
      logic [7:0] head;
      logic       avail;
   } pref_status_type;

   typedef struct packed {
      logic                 clear;
      logic                 set;
      logic [SYM_IDX_W-1:0] idx;
   } mark_ctrl_type;

   typedef struct packed {
      logic                 en;
      logic [SYM_IDX_W-1:0] addr;
      logic [COLOR_W-1:0]   color;
      logic [SYM_W-1:0]     symbol;
   } store_wr_type;

endpackage

FILE: sv/ctspi_color_store.sv
module ctspi_color_store (
   input  logic                             clock,
   input  ctspi_pkg::store_wr_type          wr,
   input  logic [ctspi_pkg::SYM_IDX_W-1:0]  rd_addr,
   output logic [ctspi_pkg::COLOR_W-1:0]    rd_color,
   output logic [ctspi_pkg::SYM_W-1:0]      rd_symbol
);

   localparam int ENTRY_W = ctspi_pkg::COLOR_W + ctspi_pkg::SYM_W;

   logic [ENTRY_W-1:0] entry_mem [ctspi_pkg::SYMBOL_COUNT];
   logic [ENTRY_W-1:0] rd_ff;

   // one write port at the fill position, one registered read port for the search
   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem[wr.addr] <= {wr.color, wr.symbol};
      end
      rd_ff <= entry_mem[rd_addr];
   end

   assign rd_color  = rd_ff[ENTRY_W-1:ctspi_pkg::SYM_W];
   assign rd_symbol = rd_ff[ctspi_pkg::SYM_W-1:0];

endmodule

FILE: sv/ctspi_pref_fifo.sv
module ctspi_pref_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  ctspi_pkg::pref_ctrl_type    ctrl,
   output ctspi_pkg::pref_status_type  status
);

   logic [7:0]                        queue_mem [ctspi_pkg::PREF_DEPTH];
   logic [ctspi_pkg::PREF_CNT_W-1:0]  count_ff;
   logic [ctspi_pkg::PREF_CNT_W-1:0]  rd_ptr_ff;
   logic [7:0]                        head_ff;
   logic                              not_full;

   assign not_full = count_ff < ctspi_pkg::PREF_CNT_W'(ctspi_pkg::PREF_DEPTH);

   // fill count and read pointer
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         count_ff  <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (ctrl.push && not_full) begin
            count_ff <= count_ff + 1'b1;
         end
         if (ctrl.pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // queue storage, head read is registered
   always_ff @(posedge clock) begin
      if (ctrl.push && not_full && !ctrl.clear) begin
         queue_mem[count_ff[ctspi_pkg::PREF_ADDR_W-1:0]] <= ctrl.push_symbol;
      end
      head_ff <= queue_mem[rd_ptr_ff[ctspi_pkg::PREF_ADDR_W-1:0]];
   end

   assign status.head  = head_ff;
   assign status.avail = rd_ptr_ff < count_ff;

endmodule

FILE: sv/ctspi_used_marks.sv
module ctspi_used_marks (
   input  logic                     clock,
   input  logic                     reset,
   input  ctspi_pkg::mark_ctrl_type ctrl,
   output logic                     used
);

   logic [ctspi_pkg::SYMBOL_COUNT-1:0] used_ff;

   // one mark per printable symbol
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         used_ff <= '0;
      end else if (ctrl.set) begin
         used_ff[ctrl.idx] <= 1'b1;
      end
   end

   // single lookup port shared by the preferred check and the scan
   assign used = used_ff[ctrl.idx];

endmodule

FILE: sv/color_to_symbol_palette_indexer.sv
// Palette indexer: clear and append transactions complete on acceptance. A classify
// transaction walks the stored colors one entry per cycle through the single read
// port of the color store. For an unseen color it tries the preferred symbol and,
// when that is not taken, scans the used marks for the lowest unused one, up to and
// including the first free one. The input is stalled until every result of the
// transaction has been taken, one result per cycle while rsp_stall is low (a second
// newline result follows a row end that is not the image end).
module color_to_symbol_palette_indexer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ctspi_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ctspi_pkg::rsp_item_type rsp_data
);

   ctspi_pkg::state_type state_ff, state_in;

   logic [ctspi_pkg::COLOR_W-1:0]   color_ff;
   logic                            nl_ff;
   logic [ctspi_pkg::SYM_CNT_W-1:0] idx_ff;
   logic                            pend_ff;
   logic [ctspi_pkg::SYM_CNT_W-1:0] entry_cnt_ff;
   logic [ctspi_pkg::SYM_W-1:0]     sym_ff;
   logic                            fresh_ff;

   logic                            accept;
   logic                            issue;
   logic                            hit;
   logic                            used;
   logic [7:0]                      pref_off;
   logic                            pref_in_range;
   logic                            pref_take;
   logic                            scan_free;
   logic                            scan_last;
   logic                            table_room;

   logic [ctspi_pkg::COLOR_W-1:0]   rd_color;
   logic [ctspi_pkg::SYM_W-1:0]     rd_symbol;

   ctspi_pkg::store_wr_type         store_wr;
   ctspi_pkg::pref_ctrl_type        pref_ctrl;
   ctspi_pkg::pref_status_type      pref_status;
   ctspi_pkg::mark_ctrl_type        mark_ctrl;

   // shared compare and index logic
   assign accept        = req_valid && (state_ff == ctspi_pkg::ST_IDLE);
   assign issue         = (state_ff == ctspi_pkg::ST_SEARCH) && (idx_ff < entry_cnt_ff);
   assign hit           = pend_ff && (rd_color == color_ff);
   assign pref_off      = pref_status.head - ctspi_pkg::SYM_FIRST;
   assign pref_in_range = (pref_status.head >= ctspi_pkg::SYM_FIRST) &&
                          (pref_status.head <= ctspi_pkg::SYM_LAST);
   assign pref_take     = (state_ff == ctspi_pkg::ST_PREF) && pref_status.avail &&
                          pref_in_range && !used;
   assign scan_free     = (state_ff == ctspi_pkg::ST_SCAN) && !used;
   assign scan_last     = idx_ff == ctspi_pkg::SYM_CNT_W'(ctspi_pkg::SYMBOL_COUNT - 1);
   assign table_room    = entry_cnt_ff < ctspi_pkg::SYM_CNT_W'(ctspi_pkg::SYMBOL_COUNT);

   // used marks: lookup index follows the active step
   always_comb begin
      mark_ctrl.clear = accept && (req_data.req_type == ctspi_pkg::REQ_CLEAR);
      mark_ctrl.set   = pref_take || scan_free;
      if (state_ff == ctspi_pkg::ST_PREF) begin
         mark_ctrl.idx = pref_off[ctspi_pkg::SYM_IDX_W-1:0];
      end else begin
         mark_ctrl.idx = idx_ff[ctspi_pkg::SYM_IDX_W-1:0];
      end
   end

   // preferred queue control
   always_comb begin
      pref_ctrl.clear       = accept && (req_data.req_type == ctspi_pkg::REQ_CLEAR);
      pref_ctrl.push        = accept && (req_data.req_type == ctspi_pkg::REQ_APPEND);
      pref_ctrl.pop         = (state_ff == ctspi_pkg::ST_PREF) && pref_status.avail;
      pref_ctrl.push_symbol = req_data.pref_symbol;
   end

   // color store fill
   always_comb begin
      store_wr.en     = (state_ff == ctspi_pkg::ST_STORE) && table_room;
      store_wr.addr   = entry_cnt_ff[ctspi_pkg::SYM_IDX_W-1:0];
      store_wr.color  = color_ff;
      store_wr.symbol = sym_ff;
   end

   ctspi_color_store u_color_store (
      .clock     (clock),
      .wr        (store_wr),
      .rd_addr   (idx_ff[ctspi_pkg::SYM_IDX_W-1:0]),
      .rd_color  (rd_color),
      .rd_symbol (rd_symbol)
   );

   ctspi_pref_fifo u_pref_fifo (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (pref_ctrl),
      .status (pref_status)
   );

   ctspi_used_marks u_used_marks (
      .clock (clock),
      .reset (reset),
      .ctrl  (mark_ctrl),
      .used  (used)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ctspi_pkg::ST_IDLE: begin
            if (accept && (req_data.req_type == ctspi_pkg::REQ_CLASSIFY)) begin
               state_in = ctspi_pkg::ST_SEARCH;
            end
         end
         ctspi_pkg::ST_SEARCH: begin
            if (hit) begin
               state_in = ctspi_pkg::ST_OUT_CELL;
            end else if (!issue) begin
               state_in = ctspi_pkg::ST_PREF;
            end
         end
         ctspi_pkg::ST_PREF: begin
            state_in = pref_take ? ctspi_pkg::ST_STORE : ctspi_pkg::ST_SCAN;
         end
         ctspi_pkg::ST_SCAN: begin
            if (scan_free || scan_last) begin
               state_in = ctspi_pkg::ST_STORE;
            end
         end
         ctspi_pkg::ST_STORE: begin
            state_in = ctspi_pkg::ST_OUT_CELL;
         end
         ctspi_pkg::ST_OUT_CELL: begin
            if (!rsp_stall) begin
               state_in = nl_ff ? ctspi_pkg::ST_OUT_NL : ctspi_pkg::ST_IDLE;
            end
         end
         ctspi_pkg::ST_OUT_NL: begin
            if (!rsp_stall) begin
               state_in = ctspi_pkg::ST_IDLE;
            end
         end
         default: state_in = ctspi_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall            = 1'b1;
      rsp_valid            = 1'b0;
      rsp_data.symbol      = sym_ff;
      rsp_data.new_color   = fresh_ff;
      rsp_data.last_of_run = !nl_ff;
      unique case (state_ff)
         ctspi_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         ctspi_pkg::ST_OUT_CELL: begin
            rsp_valid = 1'b1;
         end
         ctspi_pkg::ST_OUT_NL: begin
            rsp_valid            = 1'b1;
            rsp_data.symbol      = ctspi_pkg::SYM_NEWLINE;
            rsp_data.new_color   = 1'b0;
            rsp_data.last_of_run = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctspi_pkg::ST_IDLE;
         entry_cnt_ff <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && (req_data.req_type == ctspi_pkg::REQ_CLEAR)) begin
            entry_cnt_ff <= '0;
         end else if (store_wr.en) begin
            entry_cnt_ff <= entry_cnt_ff + 1'b1;
         end
         if (accept) begin
            pend_ff <= 1'b0;
         end else if (state_ff == ctspi_pkg::ST_SEARCH) begin
            pend_ff <= issue;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ctspi_pkg::ST_IDLE: begin
            if (accept) begin
               color_ff <= {req_data.red, req_data.green, req_data.blue};
               nl_ff    <= req_data.row_end_not_last;
               idx_ff   <= '0;
            end
         end
         ctspi_pkg::ST_SEARCH: begin
            if (issue) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (hit) begin
               sym_ff   <= rd_symbol;
               fresh_ff <= 1'b0;
            end
         end
         ctspi_pkg::ST_PREF: begin
            idx_ff   <= '0;
            fresh_ff <= 1'b1;
            if (pref_take) begin
               sym_ff <= pref_status.head[ctspi_pkg::SYM_W-1:0];
            end
         end
         ctspi_pkg::ST_SCAN: begin
            idx_ff <= idx_ff + 1'b1;
            if (scan_free) begin
               sym_ff <= ctspi_pkg::SYM_W'(idx_ff) + ctspi_pkg::SYM_FIRST[ctspi_pkg::SYM_W-1:0];
            end else if (scan_last) begin
               sym_ff <= ctspi_pkg::SYM_FALLBACK;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: sv/ctspi_checker.sv
module ctspi_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input ctspi_pkg::req_item_type req_data,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input ctspi_pkg::rsp_item_type rsp_data
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // newline results carry no new color and close the run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.symbol == ctspi_pkg::SYM_NEWLINE) |->
      !rsp_data.new_color && rsp_data.last_of_run)
      else $error("bad newline result");

   // a cell result that is not last is followed right away by the newline
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_run |=>
      rsp_valid && (rsp_data.symbol == ctspi_pkg::SYM_NEWLINE))
      else $error("missing newline after row end");

   // cell symbols are printable
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.symbol != ctspi_pkg::SYM_NEWLINE) |->
      ({1'b0, rsp_data.symbol} >= ctspi_pkg::SYM_FIRST) &&
      ({1'b0, rsp_data.symbol} <= ctspi_pkg::SYM_LAST))
      else $error("cell symbol not printable");

   // a classify transaction holds off further input
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.req_type == ctspi_pkg::REQ_CLASSIFY) |=> req_stall)
      else $error("input taken during classify");

endmodule

bind color_to_symbol_palette_indexer ctspi_checker u_ctspi_checker (.*);
